// ===== design/endstop_homing_detector_core_macros.svh =====
// Assertion macros for the endstop homing detector core.
// Taken in by the top level with an include; no other dependencies.
`ifndef ENDSTOP_HOMING_DETECTOR_CORE_MACROS_SVH
`define ENDSTOP_HOMING_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define EHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define EHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define EHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/ehd_pkg.sv =====
// Shared constants for the endstop homing detector: field widths,
// configuration register indexes and their reset values. No dependencies.
package ehd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned THR_W    = 31;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_SPD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_REV  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM   = 3'd6;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0]   RST_SPEED_THR   = 31'd32768;
  localparam logic [THR_W-1:0]   RST_CURRENT_THR = 31'd65536;
  localparam logic [COUNT_W-1:0] RST_TICK_TARGET = 16'd50;
  localparam logic [COUNT_W-1:0] RST_AVG_START   = 16'd25;
  localparam logic [THR_W-1:0]   RST_HOMING_SPD  = 31'd65536;
  localparam logic               RST_HOMING_REV  = 1'b0;
  localparam logic [THR_W-1:0]   RST_SPEED_LIM   = 31'd655360;

endpackage

// ===== design/ehd_if.sv =====
// Handshake channels of the endstop homing detector: sample items in,
// result items out and configuration writes. Depends on ehd_pkg.

interface ehd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  start_req;
  logic                                  abort;
  logic signed [ehd_pkg::SAMPLE_W-1:0]   position;
  logic signed [ehd_pkg::SAMPLE_W-1:0]   velocity;
  logic signed [ehd_pkg::SAMPLE_W-1:0]   current;

  modport source (output valid, start_req, abort, position, velocity, current,
                  input ready);
  modport sink   (input valid, start_req, abort, position, velocity, current,
                  output ready);
endinterface

interface ehd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ehd_pkg::SAMPLE_W-1:0]   vel_cmd;
  logic                                  running;
  logic                                  done_res;
  logic                                  aborted;
  logic signed [ehd_pkg::SAMPLE_W-1:0]   stop_pos;
  logic        [ehd_pkg::COUNT_W-1:0]    stall_count;

  modport source (output valid, vel_cmd, running, done_res, aborted,
                  stop_pos, stall_count, input ready);
  modport sink   (input valid, vel_cmd, running, done_res, aborted,
                  stop_pos, stall_count, output ready);
endinterface

interface ehd_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ehd_pkg::CFG_IDX_W-1:0]         index;
  logic [ehd_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/endstop_homing_detector_core.sv =====
// Endstop homing detector core: one module holding the tick sequencer,
// the homing state and a bit-serial divider.
// Depends on ehd_pkg, the ehd_*_if interfaces and the assertion macros.
//
// Each accepted item is one control tick and yields exactly one result item.
// A tick passes the stages register sample, stall test and state update;
// the input is ready again after the state update, which waits for the result
// register to be free; the result register lets the next item in while the
// previous result waits. The completion tick additionally runs the position
// average through a restoring divider that retires one quotient bit per
// cycle over the 48-bit sum, then a sign fix and saturation stage: its
// result is loaded from that stage, and the next item is taken once it has
// loaded. Configuration writes are always ready and must only be
// issued while no item is in flight.

`include "endstop_homing_detector_core_macros.svh"

module endstop_homing_detector_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ehd_in_if.sink     in_i,
  ehd_out_if.source  out_o,
  ehd_cfg_if.sink    cfg_i
);

  localparam int unsigned SW = ehd_pkg::SAMPLE_W;
  localparam int unsigned TW = ehd_pkg::THR_W;
  localparam int unsigned CW = ehd_pkg::COUNT_W;
  localparam int unsigned MW = ehd_pkg::SUM_W;
  localparam int unsigned DCNT_W = $clog2(MW);

  // Sequencer state codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STALL = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIX   = 3'd4;

  localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(MW - 1);
  localparam logic [CW-1:0]     COUNT_MAX = '1;
  localparam logic signed [MW-1:0] SUM_MAX = {1'b0, {(MW-1){1'b1}}};
  localparam logic signed [MW-1:0] SUM_MIN = {1'b1, {(MW-1){1'b0}}};
  localparam logic signed [SW-1:0] RES_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] RES_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [MW-1:0] POS_LIMIT = {{(MW-SW){1'b0}}, RES_MAX};
  localparam logic [MW-1:0] NEG_LIMIT = {{(MW-SW){1'b0}}, RES_MIN};

  // Configuration registers
  logic [TW-1:0] speed_thr_q, current_thr_q, homing_spd_q, speed_lim_q;
  logic [CW-1:0] tick_target_q, avg_start_q;
  logic          homing_rev_q;

  // Sequencer and homing state
  logic [2:0]           state_q, state_d;
  logic                 active_q;
  logic [CW-1:0]        count_q;
  logic signed [MW-1:0] sum_q;
  logic signed [SW-1:0] last_q;

  // Registered sample and stall-stage results
  logic                 start_q, abort_q, stalled_q;
  logic signed [SW-1:0] pos_q, vel_q, cur_q, cmd_q;

  // Divider
  logic [DCNT_W-1:0] div_cnt_q;
  logic [MW-1:0]     quo_q;
  logic [CW-1:0]     rem_q, divisor_q;
  logic              neg_q, zero_div_q;

  // Result register
  logic                 out_valid_q;
  logic signed [SW-1:0] out_cmd_q, out_pos_q;
  logic                 out_run_q, out_done_q, out_abo_q;
  logic [CW-1:0]        out_cnt_q;

  // ---------------------------------------------------------------------
  // Handshakes
  logic in_fire, out_free, cfg_fire;
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------------
  // Stall test and command magnitude (stall stage)
  logic [SW-1:0] vel_mag, cur_mag;
  logic [TW-1:0] cmd_mag;
  logic          stalled;
  logic signed [SW-1:0] cmd_val;

  assign vel_mag = vel_q[SW-1] ? (~vel_q + 1'b1) : vel_q;
  assign cur_mag = cur_q[SW-1] ? (~cur_q + 1'b1) : cur_q;
  assign stalled = (vel_mag < {1'b0, speed_thr_q}) && (cur_mag > {1'b0, current_thr_q});
  assign cmd_mag = (homing_spd_q < speed_lim_q) ? homing_spd_q : speed_lim_q;
  assign cmd_val = homing_rev_q ? -$signed({1'b0, cmd_mag}) : $signed({1'b0, cmd_mag});

  // ---------------------------------------------------------------------
  // State update (step stage)
  logic                 active_eff;
  logic [CW-1:0]        count_eff, count_new;
  logic signed [MW-1:0] sum_eff, sum_sat;
  logic signed [MW:0]   sum_add;
  logic                 reached, averaging;
  logic [MW-1:0]        sum_mag;

  assign active_eff = start_q || active_q;
  assign count_eff  = start_q ? '0 : count_q;
  assign sum_eff    = start_q ? '0 : sum_q;
  assign count_new  = (stalled_q && (count_eff != COUNT_MAX)) ? count_eff + 1'b1 : count_eff;
  assign reached    = (count_new >= tick_target_q);
  assign averaging  = (count_new >= avg_start_q);
  assign sum_add    = {sum_eff[MW-1], sum_eff} + {{(MW-SW+1){pos_q[SW-1]}}, pos_q};
  assign sum_mag    = sum_eff[MW-1] ? (~sum_eff + 1'b1) : sum_eff;

  always_comb begin
    if (sum_add[MW] != sum_add[MW-1]) begin
      sum_sat = sum_add[MW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_add[MW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Divider step: shift in one dividend bit, subtract when it fits
  logic [CW:0]   rem_shift;
  logic          rem_fits;
  logic [CW-1:0] rem_next;

  assign rem_shift = {rem_q, quo_q[MW-1]};
  assign rem_fits  = (rem_shift >= {1'b0, divisor_q});
  assign rem_next  = rem_fits ? CW'(rem_shift - {1'b0, divisor_q}) : rem_shift[CW-1:0];

  // Sign fix and saturation of the quotient
  logic signed [SW-1:0] fin_res;
  always_comb begin
    priority if (zero_div_q) begin
      fin_res = '0;
    end else if (neg_q) begin
      fin_res = (quo_q > NEG_LIMIT) ? RES_MIN : -$signed(quo_q[SW-1:0]);
    end else begin
      fin_res = (quo_q > POS_LIMIT) ? RES_MAX : $signed(quo_q[SW-1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) begin
        state_d = ST_STALL;
      end
      ST_STALL: state_d = ST_STEP;
      ST_STEP:  if (out_free) begin
        state_d = (active_eff && !abort_q && reached) ? ST_DIV : ST_IDLE;
      end
      ST_DIV:   if (div_cnt_q == DIV_LAST) begin
        state_d = ST_FIX;
      end
      ST_FIX:   if (out_free) begin
        state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_thr_q   <= ehd_pkg::RST_SPEED_THR;
      current_thr_q <= ehd_pkg::RST_CURRENT_THR;
      tick_target_q <= ehd_pkg::RST_TICK_TARGET;
      avg_start_q   <= ehd_pkg::RST_AVG_START;
      homing_spd_q  <= ehd_pkg::RST_HOMING_SPD;
      homing_rev_q  <= ehd_pkg::RST_HOMING_REV;
      speed_lim_q   <= ehd_pkg::RST_SPEED_LIM;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        ehd_pkg::CFG_SPEED_THR:   speed_thr_q   <= cfg_i.data[TW-1:0];
        ehd_pkg::CFG_CURRENT_THR: current_thr_q <= cfg_i.data[TW-1:0];
        ehd_pkg::CFG_TICK_TARGET: tick_target_q <= cfg_i.data[CW-1:0];
        ehd_pkg::CFG_AVG_START:   avg_start_q   <= cfg_i.data[CW-1:0];
        ehd_pkg::CFG_HOMING_SPD:  homing_spd_q  <= cfg_i.data[TW-1:0];
        ehd_pkg::CFG_HOMING_REV:  homing_rev_q  <= cfg_i.data[0];
        ehd_pkg::CFG_SPEED_LIM:   speed_lim_q   <= cfg_i.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Capture the sample item and the stall-stage results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= in_i.start_req;
      abort_q <= in_i.abort;
      pos_q   <= in_i.position;
      vel_q   <= in_i.velocity;
      cur_q   <= in_i.current;
    end
    if (state_q == ST_STALL) begin
      stalled_q <= stalled;
      cmd_q     <= cmd_val;
    end
  end

  // ---------------------------------------------------------------------
  // Homing state: commit on the step stage, last result on abort or finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      count_q  <= '0;
      sum_q    <= '0;
      last_q   <= '0;
    end else if ((state_q == ST_STEP) && out_free) begin
      priority if (!active_eff) begin
        active_q <= 1'b0;
        count_q  <= count_eff;
        sum_q    <= sum_eff;
      end else if (abort_q) begin
        active_q <= 1'b0;
        count_q  <= count_eff;
        sum_q    <= sum_eff;
        last_q   <= '0;
      end else if (reached) begin
        active_q <= 1'b0;
        count_q  <= count_new;
        sum_q    <= sum_eff;
      end else begin
        active_q <= 1'b1;
        count_q  <= count_new;
        sum_q    <= averaging ? sum_sat : sum_eff;
      end
    end else if ((state_q == ST_FIX) && out_free) begin
      last_q <= fin_res;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: load on completion, then one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (state_q == ST_DIV) begin
      div_cnt_q <= (div_cnt_q == DIV_LAST) ? '0 : div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_STEP) && (state_d == ST_DIV)) begin
      quo_q      <= sum_mag;
      rem_q      <= '0;
      neg_q      <= sum_eff[MW-1];
      zero_div_q <= (tick_target_q <= avg_start_q);
      divisor_q  <= tick_target_q - avg_start_q;
    end else if (state_q == ST_DIV) begin
      quo_q <= {quo_q[MW-2:0], rem_fits};
      rem_q <= rem_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: load from the step or fix stage, drop when taken
  logic out_load;
  assign out_load = out_free && (((state_q == ST_STEP) && (state_d == ST_IDLE)) ||
                                 (state_q == ST_FIX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == ST_FIX) begin
        out_cmd_q  <= cmd_q;
        out_run_q  <= 1'b0;
        out_done_q <= 1'b1;
        out_abo_q  <= 1'b0;
        out_pos_q  <= fin_res;
        out_cnt_q  <= count_q;
      end else begin
        priority if (!active_eff) begin
          out_cmd_q  <= '0;
          out_run_q  <= 1'b0;
          out_abo_q  <= 1'b0;
          out_pos_q  <= last_q;
          out_cnt_q  <= count_eff;
        end else if (abort_q) begin
          out_cmd_q  <= '0;
          out_run_q  <= 1'b0;
          out_abo_q  <= 1'b1;
          out_pos_q  <= '0;
          out_cnt_q  <= count_eff;
        end else begin
          out_cmd_q  <= cmd_q;
          out_run_q  <= 1'b1;
          out_abo_q  <= 1'b0;
          out_pos_q  <= last_q;
          out_cnt_q  <= count_new;
        end
        out_done_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.vel_cmd     = out_cmd_q;
  assign out_o.running     = out_run_q;
  assign out_o.done_res    = out_done_q;
  assign out_o.aborted     = out_abo_q;
  assign out_o.stop_pos    = out_pos_q;
  assign out_o.stall_count = out_cnt_q;

  // ---------------------------------------------------------------------
  // Assertions
  `EHD_ASSERT_IMP(a_out_from_stage, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_STEP || $past(state_q) == ST_FIX, "result loaded outside step or fix stage")
  `EHD_ASSERT_NXT(a_accept_to_stall, clk_i, rst_ni, in_fire, state_q == ST_STALL, "accepted item did not enter the stall stage")
  `EHD_ASSERT_IMP(a_abort_zero, clk_i, rst_ni, out_valid_q && out_abo_q, out_pos_q == '0 && out_cmd_q == '0 && !out_done_q && !out_run_q, "abort result not cleared")
  `EHD_ASSERT_IMP(a_div_count_idle, clk_i, rst_ni, state_q != ST_DIV, div_cnt_q == '0, "divider count not at zero outside division")

endmodule
